/* hw/rtl/mbq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_pkg: shared constants for the multichannel biquad cascade
// Register indexes and the widths of the delay state and the configuration data.
// ----------------------------------------------------------------------------
package mbq_pkg;
	localparam int unsigned REG_SECTIONS = 3;
	localparam int unsigned DELAY_WIDTH  = 40;
	localparam int unsigned CFG_WIDTH    = 60;
	localparam int unsigned IDX_WIDTH    = 3;

	// register indexes
	localparam logic [IDX_WIDTH-1:0] REG_S0_B   = 3'd0;
	localparam logic [IDX_WIDTH-1:0] REG_S0_A   = 3'd1;
	localparam logic [IDX_WIDTH-1:0] REG_S1_B   = 3'd2;
	localparam logic [IDX_WIDTH-1:0] REG_S1_A   = 3'd3;
	localparam logic [IDX_WIDTH-1:0] REG_S2_B   = 3'd4;
	localparam logic [IDX_WIDTH-1:0] REG_S2_A   = 3'd5;
	localparam logic [IDX_WIDTH-1:0] REG_NSEC   = 3'd6;
	localparam logic [IDX_WIDTH-1:0] REG_NCHAN  = 3'd7;
endpackage
`default_nettype wire

/* hw/rtl/multichannel_biquad_cascade.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_biquad_cascade
// Four-channel cascade of transposed direct form II biquads, delay state in RAM.
// ----------------------------------------------------------------------------
// One item holds one sample per channel. Each item passes an accept state,
// read, compute and write-back states for each (channel, section) pair that
// is filtered (read of the delay-state RAM, rounding of the section output,
// feedback terms and write back) and an issue state for the result; when no
// section or no channel is active it goes from accept straight to issue. The
// pace is set by the single shared multiply-accumulate datapath and the
// registered read of the delay-state RAM. Delay state is cleared by a sweep
// over all MAX_SECTIONS*CHANNELS entries after reset, during which no item is
// accepted. The result register lets the next item enter while a result
// waits; its result is issued once the waiting one has been taken.
module multichannel_biquad_cascade #(
	parameter int unsigned MAX_SECTIONS = 3,
	parameter int unsigned CHANNELS     = 4,
	parameter int unsigned SAMPLE_WIDTH = 16,
	parameter int unsigned COEF_WIDTH   = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [mbq_pkg::IDX_WIDTH-1:0] cfg_index,
	input  wire logic [mbq_pkg::CFG_WIDTH-1:0] cfg_data,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// sample_ch0 .. sample_ch3 from the lowest bit up
	input  wire logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	input  wire logic s_axis_tlast,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// filtered_ch0 .. filtered_ch3 from the lowest bit up
	output logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	output logic      m_axis_tlast
);
	localparam int unsigned DW     = mbq_pkg::DELAY_WIDTH;
	localparam int unsigned SW     = SAMPLE_WIDTH;
	localparam int unsigned CW     = COEF_WIDTH;
	localparam int unsigned FRAC   = CW - 2;
	localparam int unsigned DEPTH  = MAX_SECTIONS * CHANNELS;
	localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned SECW   = 2;
	localparam int unsigned CHW    = 3;
	localparam int unsigned TDW    = ((4*SAMPLE_WIDTH+7)/8)*8;
	localparam int unsigned PW     = SW + CW;
	localparam int unsigned AccW   = ((PW > DW) ? PW : DW) + 3;
	localparam int unsigned NSECL  = (MAX_SECTIONS < mbq_pkg::REG_SECTIONS) ?
		MAX_SECTIONS : mbq_pkg::REG_SECTIONS;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_CALC = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [2:0] ST_WB   = 3'd5;

	// configuration registers
	logic [3*CW-1:0] sec_b_q [mbq_pkg::REG_SECTIONS];
	logic [2*CW-1:0] sec_a_q [mbq_pkg::REG_SECTIONS];
	logic [1:0]      nsec_q;
	logic [2:0]      nch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mbq_pkg::REG_SECTIONS; i++) begin
				sec_b_q[i] <= (3*CW)'(1) << FRAC;
				sec_a_q[i] <= '0;
			end
			nsec_q <= 2'd1;
			nch_q  <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbq_pkg::REG_S0_B:  sec_b_q[0] <= cfg_data[3*CW-1:0];
				mbq_pkg::REG_S0_A:  sec_a_q[0] <= cfg_data[2*CW-1:0];
				mbq_pkg::REG_S1_B:  sec_b_q[1] <= cfg_data[3*CW-1:0];
				mbq_pkg::REG_S1_A:  sec_a_q[1] <= cfg_data[2*CW-1:0];
				mbq_pkg::REG_S2_B:  sec_b_q[2] <= cfg_data[3*CW-1:0];
				mbq_pkg::REG_S2_A:  sec_a_q[2] <= cfg_data[2*CW-1:0];
				mbq_pkg::REG_NSEC:  nsec_q <= cfg_data[1:0];
				mbq_pkg::REG_NCHAN: nch_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// effective counts
	logic [SECW-1:0] nsec_eff;
	logic [CHW-1:0]  nch_eff;
	always_comb begin
		nsec_eff = (32'(nsec_q) > NSECL) ? SECW'(NSECL) : nsec_q;
		nch_eff  = (32'(nch_q) > CHANNELS) ? CHW'(CHANNELS) : nch_q;
	end

	// control
	logic [2:0]      state_q;
	logic [SECW-1:0] sec_q;
	logic [CHW-1:0]  ch_q;
	logic [AW-1:0]   clr_q;
	logic signed [SW-1:0] x_q;
	logic signed [SW-1:0] y_q;
	logic signed [SW-1:0] in_q  [4];
	logic signed [SW-1:0] res_q [4];
	logic            last_q;

	// delay-state memories
	logic [DW-1:0] mem_first  [DEPTH];
	logic [DW-1:0] mem_second [DEPTH];
	logic [DW-1:0] rd_first_q, rd_second_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [DW-1:0] wd_first, wd_second;

	// address of the current pair
	assign raddr = AW'(32'(sec_q) * CHANNELS + 32'(ch_q));

	always_ff @(posedge clk) begin
		if (we) begin
			mem_first[waddr]  <= wd_first;
			mem_second[waddr] <= wd_second;
		end
		rd_first_q  <= mem_first[raddr];
		rd_second_q <= mem_second[raddr];
	end

	// one section step on the current channel: output first, feedback next cycle
	logic signed [CW-1:0] b0, b1, b2, a1, a2;
	logic [3*CW-1:0] bsel;
	logic [2*CW-1:0] asel;
	logic signed [AccW-1:0] acc, hv, f1, f2, lo, hi, dlo, dhi;
	logic signed [SW-1:0]   y;
	logic signed [PW-1:0]   p_b0, p_b1, p_b2, p_a1, p_a2;

	always_comb begin
		bsel = sec_b_q[0];
		asel = sec_a_q[0];
		for (int i = 0; i < mbq_pkg::REG_SECTIONS; i++) begin
			if (32'(sec_q) == i) begin
				bsel = sec_b_q[i];
				asel = sec_a_q[i];
			end
		end
		b0 = bsel[CW-1:0];
		b1 = bsel[2*CW-1:CW];
		b2 = bsel[3*CW-1:2*CW];
		a1 = asel[CW-1:0];
		a2 = asel[2*CW-1:CW];
		lo  = -(AccW'(1) <<< (SW-1));
		hi  = (AccW'(1) <<< (SW-1)) - AccW'(1);
		dlo = -(AccW'(1) <<< (DW-1));
		dhi = (AccW'(1) <<< (DW-1)) - AccW'(1);
		p_b0 = PW'(x_q) * PW'(b0);
		p_b1 = PW'(x_q) * PW'(b1);
		p_b2 = PW'(x_q) * PW'(b2);
		acc = AccW'(p_b0) + AccW'(signed'(rd_first_q)) + (AccW'(1) <<< (FRAC-1));
		hv  = acc >>> FRAC;
		if (hv < lo)      y = SW'(lo);
		else if (hv > hi) y = SW'(hi);
		else              y = SW'(hv);
		p_a1 = PW'(y_q) * PW'(a1);
		p_a2 = PW'(y_q) * PW'(a2);
		f1 = AccW'(p_b1) - AccW'(p_a1) + AccW'(signed'(rd_second_q));
		f2 = AccW'(p_b2) - AccW'(p_a2);
		if (f1 < dlo)      f1 = dlo;
		else if (f1 > dhi) f1 = dhi;
		if (f2 < dlo)      f2 = dlo;
		else if (f2 > dhi) f2 = dhi;
	end

	always_comb begin
		we        = 1'b0;
		waddr     = raddr;
		wd_first  = DW'(f1);
		wd_second = DW'(f2);
		if (state_q == ST_CLR) begin
			we = 1'b1;
			waddr = clr_q;
			wd_first = '0;
			wd_second = '0;
		end else if (state_q == ST_WB) begin
			we = 1'b1;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			sec_q   <= '0;
			ch_q    <= '0;
			x_q     <= '0;
			y_q     <= '0;
			for (int i = 0; i < 4; i++) res_q[i] <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!m_axis_tvalid || m_axis_tready))
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == DEPTH - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						sec_q <= '0;
						ch_q  <= '0;
						x_q   <= s_axis_tdata[SW-1:0];
						state_q <= (nsec_eff == '0 || nch_eff == '0) ? ST_OUT : ST_RD;
					end
				end
				ST_RD: state_q <= ST_CALC;
				ST_CALC: begin
					y_q <= y;
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (sec_q + SECW'(1) < nsec_eff) begin
						sec_q <= sec_q + SECW'(1);
						x_q   <= y_q;
						state_q <= ST_RD;
					end else begin
						res_q[ch_q[1:0]] <= y_q;
						sec_q <= '0;
						if (ch_q + CHW'(1) < nch_eff) begin
							ch_q <= ch_q + CHW'(1);
							x_q  <= in_q[ch_q[1:0] + 2'd1];
							state_q <= ST_RD;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!m_axis_tvalid || m_axis_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result assembly, inactive channels zero, input passed through when no section is active
	logic [TDW-1:0] out_data;
	always_comb begin
		out_data = '0;
		for (int i = 0; i < 4; i++) begin
			if (i < CHANNELS && 32'(i) < 32'(nch_eff))
				out_data[i*SW +: SW] = (nsec_eff == '0) ? in_q[i] : res_q[i];
		end
	end

	// item capture and result register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			for (int i = 0; i < 4; i++) in_q[i] <= s_axis_tdata[i*SW +: SW];
			last_q <= s_axis_tlast;
		end
		if (state_q == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
			m_axis_tdata <= out_data;
			m_axis_tlast <= last_q;
		end
	end

	// checks
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !s_axis_tready) else $error("accept during clear");
	a_calc_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |=> state_q == ST_CALC) else $error("read not followed by calc");
	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
		else $error("result lost");
endmodule
`default_nettype wire
